// ===== design/cld_pkg.sv =====
`timescale 1ns / 1ps
package cld_pkg;

   localparam int NUM_KW = 22;

   typedef enum logic [1:0] {
      MODE_BYTE   = 2'd0,
      MODE_IDLE   = 2'd1,
      MODE_CLIENT = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   localparam logic [1:0] ST_ACCEPTED  = 2'd0;
   localparam logic [1:0] ST_UNKNOWN   = 2'd1;
   localparam logic [1:0] ST_REFUSED   = 2'd2;
   localparam logic [1:0] ST_MALFORMED = 2'd3;

   localparam logic [4:0] KW_PING       = 5'd0;
   localparam logic [4:0] KW_BRIGHT     = 5'd3;
   localparam logic [4:0] KW_ROTATE     = 5'd4;
   localparam logic [4:0] KW_TRANSITION = 5'd9;
   localparam logic [4:0] KW_ALERT      = 5'd12;
   localparam logic [4:0] KW_GIFBEGIN   = 5'd13;
   localparam logic [4:0] KW_WIFI       = 5'd16;

   localparam logic [15:0] TIMEOUT_RESET = 16'd250;

   localparam logic [31:0] BRIGHT_LO     = 32'd0;
   localparam logic [31:0] BRIGHT_HI     = 32'd100;
   localparam logic [31:0] ROTATE_LO     = 32'd0;
   localparam logic [31:0] ROTATE_HI     = 32'd3600;
   localparam logic [31:0] TRANSITION_LO = 32'd0;
   localparam logic [31:0] TRANSITION_HI = 32'd2000;
   localparam logic [31:0] ALERT_LO      = 32'd200;
   localparam logic [31:0] ALERT_HI      = 32'd60000;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Keyword text, right-justified: the first character sits in the highest used byte.
   localparam logic [79:0] KW_STR [NUM_KW] = '{
      "PING", "STATUS", "NEXT", "BRIGHT", "ROTATE", "TIME", "LANG", "ORIENT",
      "MODE", "TRANSITION", "TONE", "CAPTION", "ALERT", "GIFBEGIN", "GIFDATA", "GIFEND",
      "WIFI", "WIFIPASS", "WIFIAPPLY", "WIFIOFF", "WIFISTAT", "TOKENGET"};

   localparam logic [3:0] KW_LEN [NUM_KW] = '{
      4'd4, 4'd6, 4'd4, 4'd6, 4'd6, 4'd4, 4'd4, 4'd6,
      4'd4, 4'd10, 4'd4, 4'd7, 4'd5, 4'd8, 4'd7, 4'd6,
      4'd4, 4'd8, 4'd9, 4'd7, 4'd8, 4'd8};

   localparam logic [1:0] PH_WS   = 2'd0;
   localparam logic [1:0] PH_DIG  = 2'd1;
   localparam logic [1:0] PH_DONE = 2'd2;

   typedef struct packed {
      logic [1:0]  phase;
      logic        neg;
      logic        ovf;
      logic [31:0] val;
   } dec_type;

   localparam dec_type DEC_INIT = '{phase: PH_WS, neg: 1'b0, ovf: 1'b0, val: 32'd0};

   typedef struct packed {
      logic       clear;
      logic       valid;
      logic [7:0] data;
      logic       channel;
   } byte_type;

   typedef struct packed {
      logic [4:0]  command;
      logic [1:0]  status;
      logic        heartbeat;
      logic [31:0] arg_first;
      logic [31:0] arg_second;
   } result_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic [7:0] kw_char(input int k, input logic [3:0] p);
      logic [3:0] sh;
      sh = KW_LEN[k] - 4'd1 - p;
      return KW_STR[k][{sh, 3'b000} +: 8];
   endfunction

   // One character of a decimal read: white space, optional sign, digits.
   function automatic dec_type dec_step(input dec_type s, input logic [7:0] c);
      dec_type    r;
      logic       dig;
      logic [7:0] d;
      logic [35:0] prod;
      r    = s;
      dig  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      d    = c - CHAR_ZERO;
      prod = {1'b0, s.val, 3'b000} + {3'b000, s.val, 1'b0} + {32'd0, d[3:0]};
      case (s.phase)
         PH_WS: begin
            if (is_ws(c)) begin
               r.phase = PH_WS;
            end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
               r.neg   = (c == CHAR_MINUS);
               r.phase = PH_DIG;
            end else if (!dig) begin
               r.phase = PH_DONE;
            end else begin
               r.phase = PH_DIG;
            end
         end
         PH_DIG: begin
            if (!dig) r.phase = PH_DONE;
         end
         default: r.phase = PH_DONE;
      endcase
      if (dig && s.phase != PH_DONE) begin
         if (prod[35:32] != 4'd0) begin
            r.val = 32'hFFFF_FFFF;
            r.ovf = 1'b1;
         end else if (!s.ovf) begin
            r.val = prod[31:0];
         end
      end
      return r;
   endfunction

   function automatic logic [31:0] dec_clamp(input dec_type s, input logic [31:0] lo,
                                             input logic [31:0] hi);
      if (s.neg && s.val != 32'd0) return lo;
      if (s.val < lo) return lo;
      if (s.val > hi) return hi;
      return s.val;
   endfunction

   function automatic logic [31:0] dec_unsigned(input dec_type s);
      if (s.ovf) return 32'hFFFF_FFFF;
      return s.neg ? (32'd0 - s.val) : s.val;
   endfunction

endpackage

// ===== design/text_command_line_decoder_unit.sv =====
`timescale 1ns / 1ps
// Two-channel command line decoder. Bytes, idle checks and client-change events arrive
// one transaction at a time; lines are held in a single line memory of 2 x MAX_LINE bytes
// with a registered read. At an LF the stored line is walked twice through the memory read
// port, once to trim white space and once to split and decode it, and no new transaction
// is taken until the walk is done and any result has entered the output register. The result
// waits in that output register.
module text_command_line_decoder_unit #(
   parameter int MAX_LINE = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data[7:0], now_ms[39:8]
   input  logic [2:0]  req_tuser,   // mode[1:0], channel[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // command[4:0], heartbeat[5], arg_first[37:6],
                                    // arg_second[69:38], zero fill[71:70]
   output logic [2:0]  rsp_tuser,   // status[1:0], from_usb[2]
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import cld_pkg::*;

   localparam int LEN_W  = $clog2(MAX_LINE + 1);
   localparam int POS_W  = $clog2(MAX_LINE);
   localparam int DEPTH  = 2 * MAX_LINE;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_TRIM  = 4'b0010,
      S_PARSE = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [15:0] timeout_ff, timeout_in;
   logic [LEN_W-1:0] len_ff [2];
   logic [LEN_W-1:0] len_in [2];
   logic        disc_ff [2];
   logic        disc_in [2];
   logic [31:0] last_ff [2];
   logic [31:0] last_in [2];

   logic             dec_ch_ff, dec_ch_in;
   logic [LEN_W-1:0] dec_len_ff, dec_len_in;
   logic [LEN_W-1:0] rd_idx_ff, rd_idx_in;
   logic [LEN_W-1:0] rd_pos_ff, rd_pos_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             found_ff, found_in;
   logic [LEN_W-1:0] beg_ff, beg_in;
   logic [LEN_W-1:0] end_ff, end_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [71:0] rsp_data_ff, rsp_data_in;
   logic [2:0]  rsp_user_ff, rsp_user_in;

   logic [7:0]  mem [DEPTH];
   logic [7:0]  mem_q_ff;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   mode_type    mode;
   logic        ch;
   logic [7:0]  rx_byte;
   logic [31:0] now;
   logic        accept;
   logic [LEN_W-1:0] limit;

   byte_type    pbyte;
   result_type  presult;

   assign mode    = mode_type'(req_tuser[1:0]);
   assign ch      = req_tuser[2];
   assign rx_byte = req_tdata[7:0];
   assign now     = req_tdata[39:8];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign wr_addr = (ch ? ADDR_W'(MAX_LINE) : ADDR_W'(0)) +
                    ADDR_W'(len_ff[ch][POS_W-1:0]);
   assign rd_addr = (dec_ch_ff ? ADDR_W'(MAX_LINE) : ADDR_W'(0)) +
                    ADDR_W'(rd_idx_ff[POS_W-1:0]);
   assign limit   = (state_ff == S_TRIM) ? dec_len_ff : end_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= rx_byte;
      mem_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         timeout_ff   <= TIMEOUT_RESET;
         len_ff[0]    <= '0;
         len_ff[1]    <= '0;
         disc_ff[0]   <= 1'b0;
         disc_ff[1]   <= 1'b0;
         last_ff[0]   <= 32'd0;
         last_ff[1]   <= 32'd0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timeout_ff   <= timeout_in;
         len_ff       <= len_in;
         disc_ff      <= disc_in;
         last_ff      <= last_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dec_ch_ff   <= dec_ch_in;
      dec_len_ff  <= dec_len_in;
      rd_idx_ff   <= rd_idx_in;
      rd_pos_ff   <= rd_pos_in;
      found_ff    <= found_in;
      beg_ff      <= beg_in;
      end_ff      <= end_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_comb begin
      state_in     = state_ff;
      timeout_in   = csr_wr_en ? csr_wr_data : timeout_ff;
      len_in       = len_ff;
      disc_in      = disc_ff;
      last_in      = last_ff;
      dec_ch_in    = dec_ch_ff;
      dec_len_in   = dec_len_ff;
      rd_idx_in    = rd_idx_ff;
      rd_pos_in    = rd_idx_ff;
      rd_vld_in    = 1'b0;
      found_in     = found_ff;
      beg_in       = beg_ff;
      end_in       = end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      wr_en        = 1'b0;
      pbyte        = '{clear: 1'b0, valid: 1'b0, data: mem_q_ff, channel: dec_ch_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (mode)
                  MODE_BYTE: begin
                     last_in[ch] = now;
                     if (rx_byte == CHAR_LF) begin
                        len_in[ch]  = '0;
                        disc_in[ch] = 1'b0;
                        dec_ch_in   = ch;
                        dec_len_in  = len_ff[ch];
                        rd_idx_in   = '0;
                        found_in    = 1'b0;
                        if (!disc_ff[ch] && len_ff[ch] != '0) state_in = S_TRIM;
                     end else if (rx_byte != CHAR_CR && !disc_ff[ch]) begin
                        if (len_ff[ch] < LEN_W'(MAX_LINE)) begin
                           wr_en      = 1'b1;
                           len_in[ch] = len_ff[ch] + LEN_W'(1);
                        end else begin
                           len_in[ch]  = '0;
                           disc_in[ch] = 1'b1;
                        end
                     end
                  end
                  MODE_IDLE: begin
                     if ((len_ff[ch] != '0 || disc_ff[ch]) &&
                         (now - last_ff[ch]) > {16'd0, timeout_ff}) begin
                        len_in[ch]  = '0;
                        disc_in[ch] = 1'b0;
                     end
                  end
                  MODE_CLIENT: begin
                     len_in[1]  = '0;
                     disc_in[1] = 1'b0;
                     last_in[1] = now;
                  end
                  default: ;
               endcase
            end
         end
         S_TRIM: begin
            if (rd_idx_ff != limit) begin
               rd_vld_in = 1'b1;
               rd_idx_in = rd_idx_ff + LEN_W'(1);
            end
            if (rd_vld_ff && !is_ws(mem_q_ff)) begin
               if (!found_ff) beg_in = rd_pos_ff;
               found_in = 1'b1;
               end_in   = rd_pos_ff + LEN_W'(1);
            end
            if (rd_idx_ff == limit && !rd_vld_ff) begin
               // A line of white space alone gives no result.
               if (found_ff) begin
                  state_in    = S_PARSE;
                  rd_idx_in   = beg_ff;
                  pbyte.clear = 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_PARSE: begin
            if (rd_idx_ff != limit) begin
               rd_vld_in = 1'b1;
               rd_idx_in = rd_idx_ff + LEN_W'(1);
            end
            pbyte.valid = rd_vld_ff;
            if (rd_idx_ff == limit && !rd_vld_ff) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, presult.arg_second, presult.arg_first,
                               presult.heartbeat, presult.command};
               rsp_user_in  = {!dec_ch_ff, presult.status};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   cld_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .byte_in (pbyte),
      .result  (presult)
   );

endmodule

// ===== design/cld_parser.sv =====
`timescale 1ns / 1ps
module cld_parser (
   input  logic                clock,
   input  logic                reset,
   input  cld_pkg::byte_type   byte_in,
   output cld_pkg::result_type result
);
   import cld_pkg::*;

   logic [3:0]        kpos_ff, kpos_in;
   logic [NUM_KW-1:0] match_ff, match_in;
   logic [1:0]        colons_ff, colons_in;
   dec_type           dec_a_ff, dec_a_in;
   dec_type           dec_b_ff, dec_b_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         kpos_ff   <= 4'd0;
         match_ff  <= '1;
         colons_ff <= 2'd0;
         dec_a_ff  <= DEC_INIT;
         dec_b_ff  <= DEC_INIT;
      end else begin
         kpos_ff   <= kpos_in;
         match_ff  <= match_in;
         colons_ff <= colons_in;
         dec_a_ff  <= dec_a_in;
         dec_b_ff  <= dec_b_in;
      end
   end

   always_comb begin
      kpos_in   = kpos_ff;
      match_in  = match_ff;
      colons_in = colons_ff;
      dec_a_in  = dec_a_ff;
      dec_b_in  = dec_b_ff;
      if (byte_in.clear) begin
         kpos_in   = 4'd0;
         match_in  = '1;
         colons_in = 2'd0;
         dec_a_in  = DEC_INIT;
         dec_b_in  = DEC_INIT;
      end else if (byte_in.valid) begin
         if (colons_ff == 2'd0) begin
            if (byte_in.data == CHAR_COLON) begin
               colons_in = 2'd1;
            end else begin
               for (int k = 0; k < NUM_KW; k++) begin
                  match_in[k] = match_ff[k] && (kpos_ff < KW_LEN[k]) &&
                                (kw_char(k, kpos_ff) == byte_in.data);
               end
               if (kpos_ff != 4'hF) kpos_in = kpos_ff + 4'd1;
            end
         end else begin
            // Every byte after the first colon feeds the first number; the read stops
            // by itself at the second colon.
            dec_a_in = dec_step(dec_a_ff, byte_in.data);
            if (colons_ff == 2'd2) dec_b_in = dec_step(dec_b_ff, byte_in.data);
            if (colons_ff == 2'd1 && byte_in.data == CHAR_COLON) colons_in = 2'd2;
         end
      end
   end

   logic       found;
   logic [4:0] fcode;

   always_comb begin
      found = 1'b0;
      fcode = KW_PING;
      for (int k = NUM_KW - 1; k >= 1; k--) begin
         if (match_ff[k] && kpos_ff == KW_LEN[k]) begin
            found = 1'b1;
            fcode = 5'(k);
         end
      end

      result = '0;
      if (colons_ff == 2'd0 && match_ff[0] && kpos_ff == KW_LEN[0]) begin
         result.command   = KW_PING;
         result.heartbeat = 1'b1;
      end else if (!found) begin
         result.status = ST_UNKNOWN;
      end else begin
         result.command = fcode;
         if (byte_in.channel && fcode >= KW_WIFI) begin
            result.status = ST_REFUSED;
         end else begin
            result.heartbeat = 1'b1;
            case (fcode)
               KW_BRIGHT:     result.arg_first = dec_clamp(dec_a_ff, BRIGHT_LO, BRIGHT_HI);
               KW_ROTATE:     result.arg_first = dec_clamp(dec_a_ff, ROTATE_LO, ROTATE_HI);
               KW_TRANSITION: result.arg_first = dec_clamp(dec_a_ff, TRANSITION_LO,
                                                           TRANSITION_HI);
               KW_ALERT:      result.arg_first = dec_clamp(dec_a_ff, ALERT_LO, ALERT_HI);
               KW_GIFBEGIN: begin
                  if (colons_ff != 2'd2) begin
                     result.status = ST_MALFORMED;
                  end else begin
                     result.arg_first  = dec_unsigned(dec_a_ff);
                     result.arg_second = dec_unsigned(dec_b_ff);
                  end
               end
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import cld_pkg::*;

   localparam int LINE_MAX = 512;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int HOLD_CYCLES = 3000;
   localparam int RANDOM_ITEMS = 150;

   typedef struct packed {
      logic [4:0]  command;
      logic [1:0]  status;
      logic        from_usb;
      logic        heartbeat;
      logic [31:0] arg_first;
      logic [31:0] arg_second;
   } decoded_type;

   typedef struct {
      mode_type    mode;
      logic        channel;
      logic [7:0]  data;
      logic [31:0] now_ms;
      logic        has_known;
      decoded_type known;
   } stim_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   text_command_line_decoder_unit #(.MAX_LINE(LINE_MAX)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Predictor state, one copy per channel but for the shared timeout.
   logic [15:0] mdl_timeout;
   logic [7:0]  mdl_line [2][LINE_MAX];
   int unsigned mdl_len [2];
   logic        mdl_drop [2];
   logic [31:0] mdl_last [2];

   decoded_type pending_lines[$];
   int          mismatches = 0;
   int          sender_idle_pct;
   int          receiver_idle_pct;
   int          hold_cycles;
   logic        hold_req;
   logic        hold_seen;
   int          quiet_cycles;
   logic        timed_out;
   logic [31:0] clock_ms;

   string kw_names [NUM_KW] = '{
      "PING", "STATUS", "NEXT", "BRIGHT", "ROTATE", "TIME", "LANG", "ORIENT",
      "MODE", "TRANSITION", "TONE", "CAPTION", "ALERT", "GIFBEGIN", "GIFDATA", "GIFEND",
      "WIFI", "WIFIPASS", "WIFIAPPLY", "WIFIOFF", "WIFISTAT", "TOKENGET"};

   function automatic logic white(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic word_is(input int ch, input int b, input int n, input int k);
      string w;
      w = kw_names[k];
      if (n != w.len()) return 1'b0;
      for (int i = 0; i < n; i++)
         if (mdl_line[ch][b + i] != w[i]) return 1'b0;
      return 1'b1;
   endfunction

   // Parses white space, a sign and digits; saturates on overflow.
   function automatic logic [31:0] parse_number(input int ch, input int b, input int n,
                                                output logic neg, output logic ovf);
      int          i;
      logic [31:0] v;
      logic [31:0] d;
      i = 0;
      v = 0;
      neg = 1'b0;
      ovf = 1'b0;
      while (i < n && white(mdl_line[ch][b + i])) i++;
      if (i < n && (mdl_line[ch][b + i] == CHAR_PLUS || mdl_line[ch][b + i] == CHAR_MINUS))
      begin
         neg = mdl_line[ch][b + i] == CHAR_MINUS;
         i++;
      end
      while (i < n && mdl_line[ch][b + i] >= CHAR_ZERO && mdl_line[ch][b + i] <= CHAR_NINE)
      begin
         d = mdl_line[ch][b + i] - CHAR_ZERO;
         if (v > (32'hFFFF_FFFF - d) / 10) begin
            v = 32'hFFFF_FFFF;
            ovf = 1'b1;
         end else if (!ovf) begin
            v = v * 10 + d;
         end
         i++;
      end
      return v;
   endfunction

   function automatic logic [31:0] clamped_arg(input int ch, input int b, input int n,
                                               input logic [31:0] lo, input logic [31:0] hi);
      logic        neg, ovf;
      logic [31:0] v;
      v = parse_number(ch, b, n, neg, ovf);
      if (neg && v != 0) return lo;
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [31:0] wrapped_arg(input int ch, input int b, input int n);
      logic        neg, ovf;
      logic [31:0] v;
      v = parse_number(ch, b, n, neg, ovf);
      if (ovf) return 32'hFFFF_FFFF;
      return neg ? 32'd0 - v : v;
   endfunction

   function automatic logic decode_line(input int ch, output decoded_type r);
      int b, e, colon, vb, vn, sp, found;
      b = 0;
      e = mdl_len[ch];
      found = -1;
      r = '0;
      r.from_usb = ch == 0;
      while (b < e && white(mdl_line[ch][b])) b++;
      while (e > b && white(mdl_line[ch][e - 1])) e--;
      if (b == e) return 1'b0;
      if (word_is(ch, b, e - b, KW_PING)) begin
         r.command = KW_PING;
         r.heartbeat = 1'b1;
         return 1'b1;
      end
      colon = e;
      for (int i = b; i < e; i++)
         if (mdl_line[ch][i] == CHAR_COLON) begin
            colon = i;
            break;
         end
      vb = colon < e ? colon + 1 : e;
      vn = e - vb;
      for (int k = 1; k < NUM_KW; k++)
         if (found < 0 && word_is(ch, b, colon - b, k)) found = k;
      if (found < 0) begin
         r.status = ST_UNKNOWN;
         return 1'b1;
      end
      r.command = 5'(found);
      if (ch != 0 && r.command >= KW_WIFI) begin
         r.status = ST_REFUSED;
         return 1'b1;
      end
      r.heartbeat = 1'b1;
      case (r.command)
         KW_BRIGHT:     r.arg_first = clamped_arg(ch, vb, vn, BRIGHT_LO, BRIGHT_HI);
         KW_ROTATE:     r.arg_first = clamped_arg(ch, vb, vn, ROTATE_LO, ROTATE_HI);
         KW_TRANSITION: r.arg_first = clamped_arg(ch, vb, vn, TRANSITION_LO, TRANSITION_HI);
         KW_ALERT:      r.arg_first = clamped_arg(ch, vb, vn, ALERT_LO, ALERT_HI);
         KW_GIFBEGIN: begin
            sp = vn;
            for (int i = 0; i < vn; i++)
               if (sp == vn && mdl_line[ch][vb + i] == CHAR_COLON) sp = i;
            if (sp == vn) begin
               r.status = ST_MALFORMED;
            end else begin
               r.arg_first = wrapped_arg(ch, vb, sp);
               r.arg_second = wrapped_arg(ch, vb + sp + 1, vn - sp - 1);
            end
         end
         default: ;
      endcase
      return 1'b1;
   endfunction

   function automatic logic predict_step(input mode_type mode, input logic ch,
                                         input logic [7:0] d, input logic [31:0] now,
                                         output decoded_type r);
      logic got;
      got = 1'b0;
      r = '0;
      case (mode)
         MODE_BYTE: begin
            mdl_last[ch] = now;
            if (d == CHAR_LF) begin
               if (!mdl_drop[ch]) got = decode_line(ch, r);
               mdl_len[ch] = 0;
               mdl_drop[ch] = 1'b0;
            end else if (d != CHAR_CR && !mdl_drop[ch]) begin
               if (mdl_len[ch] < LINE_MAX) begin
                  mdl_line[ch][mdl_len[ch]] = d;
                  mdl_len[ch]++;
               end else begin
                  mdl_len[ch] = 0;
                  mdl_drop[ch] = 1'b1;
               end
            end
         end
         MODE_IDLE: begin
            if ((mdl_len[ch] > 0 || mdl_drop[ch]) && now - mdl_last[ch] > mdl_timeout) begin
               mdl_len[ch] = 0;
               mdl_drop[ch] = 1'b0;
            end
         end
         MODE_CLIENT: begin
            mdl_len[1] = 0;
            mdl_drop[1] = 1'b0;
            mdl_last[1] = now;
         end
         default: ;
      endcase
      return got;
   endfunction

   // Drives one transaction and waits for it to be taken. Valid stays high after the accepting
   // edge; in the same time step drain drops it, and the next offer drops it or keeps it up.
   task automatic offer(input mode_type mode, input logic ch, input logic [7:0] d,
                        input logic [31:0] now, input logic has_known,
                        input decoded_type known);
      decoded_type r;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      if (predict_step(mode, ch, d, now, r)) begin
         if (has_known && r != known)
            $display("directed row disagrees with predictor: %h vs %h", known, r);
         pending_lines.push_back(has_known ? known : r);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {now, d};
      req_tuser <= {ch, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_text(input logic ch, input string s);
      decoded_type none;
      none = '0;
      for (int i = 0; i < s.len(); i++) begin
         clock_ms += $urandom_range(3);
         offer(MODE_BYTE, ch, s[i], clock_ms, 1'b0, none);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (2 * LINE_MAX + 40) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      mdl_timeout = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic string random_number();
      string s;
      case ($urandom_range(5))
         0: s = "";
         1: s = "-";
         2: s = "+";
         3: s = " ";
         default: s = "";
      endcase
      if ($urandom_range(9) == 0) return {s, "99999999999"};
      return {s, $sformatf("%0d", $urandom_range($urandom_range(1) ? 70000 : 150))};
   endfunction

   function automatic string random_line();
      string s, k;
      k = kw_names[$urandom_range(NUM_KW - 1)];
      if ($urandom_range(9) == 0) k = "PONG";
      if ($urandom_range(15) == 0) k = "ping";
      s = k;
      case ($urandom_range(3))
         0: ;
         1: s = {s, ":", random_number()};
         2: s = {s, ":", random_number(), ":", random_number()};
         default: s = {s, ": ", random_number(), " "};
      endcase
      if (k == "GIFBEGIN" && $urandom_range(1))
         s = {k, ":", random_number(), ":", random_number()};
      if ($urandom_range(3) == 0) s = {" \t", s};
      if ($urandom_range(3) == 0) s = {s, " \r"};
      if ($urandom_range(19) == 0) s = {s, "\x00X"};
      return {s, "\n"};
   endfunction

   // Receiver side.
   always @(posedge clock) begin
      decoded_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_cycles <= 0;
         hold_seen <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.command = rsp_tdata[4:0];
            got.heartbeat = rsp_tdata[5];
            got.arg_first = rsp_tdata[37:6];
            got.arg_second = rsp_tdata[69:38];
            got.status = rsp_tuser[1:0];
            got.from_usb = rsp_tuser[2];
            if (pending_lines.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected line result %h", got);
            end else begin
               want = pending_lines.pop_front();
               if (got != want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"line result mismatch: cmd %0d/%0d st %0d/%0d usb %0d/%0d",
                               " hb %0d/%0d a1 %h/%h a2 %h/%h"},
                              want.command, got.command, want.status, got.status,
                              want.from_usb, got.from_usb, want.heartbeat, got.heartbeat,
                              want.arg_first, got.arg_first, want.arg_second, got.arg_second);
               end
            end
         end
         if (hold_req && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_cycles <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= $urandom_range(99) >= receiver_idle_pct;
         end
      end
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** text_command_line_decoder_unit: FAILED **");
            $finish;
         end
      end
   end

   stim_type    rows[$];
   decoded_type zero_res;

   function automatic stim_type row(input mode_type m, input logic ch, input logic [7:0] d,
                                    input logic [31:0] now);
      stim_type s;
      s.mode = m;
      s.channel = ch;
      s.data = d;
      s.now_ms = now;
      s.has_known = 1'b0;
      s.known = '0;
      return s;
   endfunction

   initial begin
      stim_type s;
      string    line;
      int       phase_pick;
      int       last_phase;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      hold_req = 1'b0;
      sender_idle_pct = 21;
      receiver_idle_pct = 66;
      clock_ms = 32'd1000;
      zero_res = '0;
      last_phase = -1;
      mdl_timeout = TIMEOUT_RESET;
      for (int c = 0; c < 2; c++) begin
         mdl_len[c] = 0;
         mdl_drop[c] = 1'b0;
         mdl_last[c] = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: PING on USB, empty line, ignored mode, extreme byte values,
      // idle drop and client change; a refused network command follows the table.
      rows.push_back(row(MODE_BYTE, 1'b0, "P", 32'd0));
      rows.push_back(row(MODE_BYTE, 1'b0, "I", 32'd0));
      rows.push_back(row(MODE_BYTE, 1'b0, "N", 32'd0));
      rows.push_back(row(MODE_BYTE, 1'b0, "G", 32'd0));
      s = row(MODE_BYTE, 1'b0, CHAR_LF, 32'hFFFF_FFFF);
      s.has_known = 1'b1;
      s.known = '{command: KW_PING, status: ST_ACCEPTED, from_usb: 1'b1, heartbeat: 1'b1,
                  arg_first: 32'd0, arg_second: 32'd0};
      rows.push_back(s);
      rows.push_back(row(MODE_BYTE, 1'b1, 8'h20, 32'd5));
      rows.push_back(row(MODE_BYTE, 1'b1, CHAR_CR, 32'd5));
      rows.push_back(row(MODE_BYTE, 1'b1, CHAR_LF, 32'd5));
      rows.push_back(row(MODE_NONE, 1'b1, 8'hFF, 32'hFFFF_FFFF));
      rows.push_back(row(MODE_BYTE, 1'b1, 8'hFF, 32'd10));
      rows.push_back(row(MODE_BYTE, 1'b1, 8'h00, 32'd10));
      rows.push_back(row(MODE_IDLE, 1'b1, 8'h00, 32'd260));
      rows.push_back(row(MODE_IDLE, 1'b1, 8'h00, 32'd261));
      rows.push_back(row(MODE_BYTE, 1'b1, "X", 32'd300));
      rows.push_back(row(MODE_CLIENT, 1'b0, 8'h00, 32'd301));
      rows.push_back(row(MODE_BYTE, 1'b1, CHAR_LF, 32'd302));
      foreach (rows[i])
         offer(rows[i].mode, rows[i].channel, rows[i].data, rows[i].now_ms,
               rows[i].has_known, rows[i].known);
      clock_ms = 32'd400;
      send_text(1'b1, "WIFIPASS:x\n");
      send_text(1'b0, "GIFBEGIN:4294967296:-1\n");
      send_text(1'b0, "ALERT:-5\n");
      send_text(1'b0, "BRIGHT\n");
      send_text(1'b0, "PING:\n");
      send_text(1'b0, "GIFBEGIN:12\n");

      // Overlong line followed by its LF.
      for (int i = 0; i < LINE_MAX + 2; i++)
         offer(MODE_BYTE, 1'b0, "A", clock_ms, 1'b0, zero_res);
      send_text(1'b0, "\nTIME\n");

      write_timeout(16'd0);
      send_text(1'b0, "ROTA");
      offer(MODE_IDLE, 1'b0, 8'h00, clock_ms + 1, 1'b0, zero_res);
      send_text(1'b0, "TE:9999\n");

      // Long receiver hold-off while the sender keeps going.
      hold_req = 1'b1;
      for (int i = 0; i < 10; i++) send_text(i[0], "STATUS:1\n");
      drain();

      for (int n = 0; n < RANDOM_ITEMS; ) begin
         phase_pick = (n * 3) / RANDOM_ITEMS;
         if (phase_pick != last_phase) begin
            last_phase = phase_pick;
            case (phase_pick)
               0: write_timeout(16'hFFFF);
               1: begin
                  write_timeout(16'd20);
                  sender_idle_pct = 66;
                  receiver_idle_pct = 21;
               end
               default: begin
                  write_timeout(TIMEOUT_RESET);
                  sender_idle_pct = 0;
                  receiver_idle_pct = 0;
               end
            endcase
         end
         case ($urandom_range(19))
            0: begin
               offer(MODE_IDLE, 1'($urandom_range(1)), 8'($urandom_range(255)),
                     clock_ms + $urandom_range(300), 1'b0, zero_res);
               n++;
            end
            1: begin
               offer(mode_type'($urandom_range(2, 3)), 1'($urandom_range(1)),
                     8'($urandom_range(255)), $urandom, 1'b0, zero_res);
               n++;
            end
            2: begin
               offer(MODE_BYTE, 1'($urandom_range(1)), 8'($urandom_range(255)), clock_ms,
                     1'b0, zero_res);
               n++;
            end
            3: clock_ms += $urandom_range(40);
            default: begin
               line = random_line();
               send_text(1'($urandom_range(1)), line);
               n += line.len();
            end
         endcase
      end

      drain();
      if (mismatches == 0 && pending_lines.size() == 0) begin
         $display("** text_command_line_decoder_unit: PASSED **");
      end else begin
         $display("** text_command_line_decoder_unit: FAILED **");
      end
      $finish;
   end

endmodule
